/* design/dwu_pkg.sv */
// ---------------------------------------------------------------------------
// dwu_pkg
// Shared types and constants of the congestion window update block.
// ---------------------------------------------------------------------------
package dwu_pkg;

	// one segment in bytes, also the lower window bound
	localparam logic [31:0] MSS_BYTES = 32'd1448;
	// fraction scale, 2^32-1
	localparam logic [31:0] FRAC_ONE  = 32'hFFFF_FFFF;

	// register indexes on the configuration port (paddr[3:2])
	typedef enum logic [1:0] {
		REG_DEFAULT_RTT = 2'd0,
		REG_EWMA_WEIGHT = 2'd1,
		REG_SEND_BUFFER = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FRAC_MUL,
		ST_FRAC_DIV,
		ST_MIX_MUL1,
		ST_MIX_MUL2,
		ST_MIX_DIV,
		ST_CUT_MUL,
		ST_CUT_DIV,
		ST_AI_MUL,
		ST_AI_DIV,
		ST_DONE
	} state_t;

endpackage

/* design/dwu_mac.sv */
// ---------------------------------------------------------------------------
// dwu_mac
// Bit-serial multiply-accumulate: result = acc_in + a * b, one multiplier
// bit per cycle.
// ---------------------------------------------------------------------------
module dwu_mac import dwu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [63:0] acc_in,
	output logic        busy,
	output logic        done,
	output logic [63:0] result
);

	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= acc_in;
			a_q   <= {32'd0, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;

endmodule

/* design/dwu_div.sv */
// ---------------------------------------------------------------------------
// dwu_div
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Divisor must be non-zero.
// ---------------------------------------------------------------------------
module dwu_div import dwu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[63]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/dctcp_window_update.sv */
// ---------------------------------------------------------------------------
// dctcp_window_update
// DCTCP-style congestion window update for one flow, one word per interval.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, one per control
//   interval. One result word leaves on m_tvalid/m_tready/m_tdata for every
//   input word. Registers (default RTT, EWMA weight, send buffer size) sit
//   on the APB port at byte addresses 0, 4 and 8.
//   Slow start or loss passes from acceptance through the decision state
//   to the result. Congestion avoidance runs a shared bit-serial multiplier
//   and a shared bit-serial divider: an interval with no acked bytes skips
//   the EWMA update, any interval with acked bytes runs the EWMA update
//   first. One word is in work at a time, so the block takes no new word
//   until the result of the last one is loaded into the output register.
//   Reset: window 1448 bytes, ECN average zero, slow start on, registers at
//   their defaults. No clearing pass.
//   When the receiver stalls, the result holds in the output register; the
//   block still takes one more word, works it out and holds it, taking
//   nothing further until the waiting result is handed over.
// ---------------------------------------------------------------------------
module dctcp_window_update import dwu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] measured_rtt, [63:32] acked_bytes, [95:64] marked_bytes,
	// [127:96] drop_count, [143:128] retransmit_count
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] new_window, [63:32] rtt_used, [95:64] mark_fraction,
	// [96] in_slow_start, [103:97] zero
	output logic [103:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t      state_q, state_d;

	logic [31:0] default_rtt_q, ewma_weight_q, send_buffer_q;
	logic [31:0] rtt_q, acked_q, marked_q, win_q, avg_q;
	logic        loss_q, ss_q, launched_q;

	logic        out_valid_q;
	logic [31:0] out_win_q, out_rtt_q, out_frac_q;
	logic        out_ss_q;

	logic        mac_start, mac_busy, mac_done;
	logic [31:0] mac_a, mac_b;
	logic [63:0] mac_acc, mac_res;
	logic        div_start, div_busy, div_done;
	logic [63:0] div_dividend, div_quo;
	logic [31:0] div_divisor;

	logic        in_acc, load_out, cfg_wr;
	logic        ss_next;
	logic [32:0] ss_sum, ai_sum;
	logic [31:0] clamp_lo, clamp_win;
	logic        unit_done;
	reg_idx_t    reg_idx;

	assign in_acc  = s_tvalid && s_tready;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_rtt_q <= 32'd18;
			ewma_weight_q <= 32'd268435456;
			send_buffer_q <= 32'd65536;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DEFAULT_RTT: default_rtt_q <= pwdata;
				REG_EWMA_WEIGHT: ewma_weight_q <= pwdata;
				REG_SEND_BUFFER: send_buffer_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			REG_DEFAULT_RTT: prdata = default_rtt_q;
			REG_EWMA_WEIGHT: prdata = ewma_weight_q;
			REG_SEND_BUFFER: prdata = send_buffer_q;
			default:         prdata = '0;
		endcase
	end

	// slow start decision and sums
	always_comb begin
		ss_sum    = {1'b0, win_q} + {1'b0, acked_q};
		ss_next   = ss_q && !loss_q && (marked_q == 32'd0);
		ai_sum    = {1'b0, win_q} + {1'b0, div_quo[31:0]};
		clamp_lo  = (win_q < MSS_BYTES) ? MSS_BYTES : win_q;
		clamp_win = (clamp_lo > send_buffer_q) ? send_buffer_q : clamp_lo;
	end

	// arithmetic unit that finishes the current state
	always_comb begin
		unique case (state_q) inside
			ST_FRAC_MUL, ST_MIX_MUL1, ST_MIX_MUL2, ST_CUT_MUL, ST_AI_MUL:
				unit_done = mac_done;
			ST_FRAC_DIV, ST_MIX_DIV, ST_CUT_DIV, ST_AI_DIV:
				unit_done = div_done;
			default:
				unit_done = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (in_acc)
					state_d = ST_DECIDE;
			ST_DECIDE:
				if (ss_next || loss_q)
					state_d = ST_DONE;
				else if (acked_q != 32'd0)
					state_d = ST_FRAC_MUL;
				else if (marked_q != 32'd0)
					state_d = ST_CUT_MUL;
				else if (win_q != 32'd0)
					state_d = ST_AI_MUL;
				else
					state_d = ST_DONE;
			ST_FRAC_MUL: if (unit_done) state_d = ST_FRAC_DIV;
			ST_FRAC_DIV: if (unit_done) state_d = ST_MIX_MUL1;
			ST_MIX_MUL1: if (unit_done) state_d = ST_MIX_MUL2;
			ST_MIX_MUL2: if (unit_done) state_d = ST_MIX_DIV;
			ST_MIX_DIV:
				if (unit_done)
					state_d = (marked_q != 32'd0) ? ST_CUT_MUL :
						((win_q != 32'd0) ? ST_AI_MUL : ST_DONE);
			ST_CUT_MUL:  if (unit_done) state_d = ST_CUT_DIV;
			ST_CUT_DIV:  if (unit_done) state_d = ST_DONE;
			ST_AI_MUL:   if (unit_done) state_d = ST_AI_DIV;
			ST_AI_DIV:   if (unit_done) state_d = ST_DONE;
			ST_DONE:
				if (!out_valid_q || m_tready)
					state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs: handshakes, unit launches and operands
	always_comb begin
		s_tready     = 1'b0;
		load_out     = 1'b0;
		mac_start    = 1'b0;
		div_start    = 1'b0;
		mac_a        = '0;
		mac_b        = '0;
		mac_acc      = '0;
		div_dividend = mac_res;
		div_divisor  = FRAC_ONE;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DONE: load_out = !out_valid_q || m_tready;
			ST_FRAC_MUL: begin
				mac_start = !launched_q;
				mac_a     = marked_q;
				mac_b     = FRAC_ONE;
			end
			ST_FRAC_DIV: begin
				div_start   = !launched_q;
				div_divisor = acked_q;
			end
			ST_MIX_MUL1: begin
				mac_start = !launched_q;
				mac_a     = div_quo[31:0];
				mac_b     = ewma_weight_q;
			end
			ST_MIX_MUL2: begin
				mac_start = !launched_q;
				mac_a     = avg_q;
				mac_b     = ~ewma_weight_q;
				mac_acc   = mac_res;
			end
			ST_MIX_DIV: div_start = !launched_q;
			ST_CUT_MUL: begin
				mac_start = !launched_q;
				mac_a     = win_q;
				mac_b     = ~{1'b0, avg_q[31:1]};
			end
			ST_CUT_DIV: div_start = !launched_q;
			ST_AI_MUL: begin
				mac_start = !launched_q;
				mac_a     = acked_q;
				mac_b     = MSS_BYTES;
			end
			ST_AI_DIV: begin
				div_start   = !launched_q;
				div_divisor = win_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			win_q       <= MSS_BYTES;
			avg_q       <= '0;
			ss_q        <= 1'b1;
		end else begin
			state_q <= state_d;
			if (mac_start || div_start)
				launched_q <= 1'b1;
			else if (unit_done)
				launched_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			// flow state updates
			unique case (state_q)
				ST_DECIDE: begin
					ss_q <= ss_next;
					if (ss_next) begin
						if (ss_sum[31:0] > win_q)
							win_q <= ss_sum[31:0];
					end else if (loss_q)
						win_q <= {1'b0, win_q[31:1]};
				end
				ST_MIX_DIV: if (unit_done) avg_q <= div_quo[31:0];
				ST_CUT_DIV: if (unit_done) win_q <= div_quo[31:0];
				ST_AI_DIV:
					if (unit_done && !ai_sum[32] && (ai_sum[31:0] > win_q))
						win_q <= ai_sum[31:0];
				ST_DONE: if (load_out) win_q <= clamp_win;
				default: ;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rtt_q    <= (s_tdata[31:0] == 32'd0) ? default_rtt_q : s_tdata[31:0];
			acked_q  <= s_tdata[63:32];
			marked_q <= s_tdata[95:64];
			loss_q   <= (s_tdata[127:96] != 32'd0) || (s_tdata[143:128] != 16'd0);
		end else if (state_q == ST_DECIDE && !ss_next && !loss_q &&
				acked_q != 32'd0 && marked_q > acked_q) begin
			marked_q <= acked_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_win_q  <= clamp_win;
			out_rtt_q  <= rtt_q;
			out_frac_q <= avg_q;
			out_ss_q   <= ss_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_ss_q, out_frac_q, out_rtt_q, out_win_q};

	dwu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      (mac_a),
		.b      (mac_b),
		.acc_in (mac_acc),
		.busy   (mac_busy),
		.done   (mac_done),
		.result (mac_res)
	);

	dwu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// the two serial units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_busy && div_busy))
		else $error("multiplier and divider busy together");

	// a word is only taken when no earlier one is in work
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_DECIDE)
		else $error("word accepted outside idle");

	// a launched unit is never restarted before it finishes
	a_no_relaunch: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_start || div_start) |=> !(mac_start || div_start))
		else $error("arithmetic unit restarted");

	// a loaded window sits at or above one segment unless the buffer bound is lower
	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_win_q >= MSS_BYTES) || (out_win_q == $past(send_buffer_q)))
		else $error("window out of range");

endmodule

/* test/tb_dctcp_window_update.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dctcp_window_update
// Self-checking bench for the congestion window update block. Feedback words
// go in on the input stream, each result word is checked field by field
// against an in-bench window predictor. Registers are changed over the APB
// port between phases, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module tb_dctcp_window_update;
	import dwu_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam logic [63:0] FRAC = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] rexmits;
		logic [31:0] drops;
		logic [31:0] marked;
		logic [31:0] acked;
		logic [31:0] rtt;
	} feedback_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic        slow;
		logic [31:0] frac;
		logic [31:0] rtt_used;
		logic [31:0] window;
	} window_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	dctcp_window_update dut (.*);

	always #5 clk = ~clk;

	// predictor copy of registers and state
	logic [31:0] cfg_rtt, cfg_weight, cfg_sndbuf;
	logic [31:0] win_q, avg_q;
	logic        slow_q;

	window_word_t expected_words[$];
	int errors = 0, checked = 0, cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, checked);
	endtask

	// next window state for one feedback word
	function automatic window_word_t predict_window(input feedback_t f);
		window_word_t r;
		logic [31:0] w, mk, nxt;
		logic [63:0] fr, keep, incr;
		logic [127:0] mix;
		bit loss;
		w = win_q;
		mk = f.marked;
		loss = (f.drops != 0) || (f.rexmits != 0);
		r = '0;
		r.rtt_used = (f.rtt == 0) ? cfg_rtt : f.rtt;
		if (slow_q) begin
			if (!loss && mk == 0) begin
				nxt = w + f.acked;
				if (nxt > w) w = nxt;
			end else slow_q = 1'b0;
		end
		if (!slow_q) begin
			if (loss) w = w / 2;
			else begin
				if (f.acked != 0) begin
					if (mk > f.acked) mk = f.acked;
					fr = ({32'd0, mk} * FRAC) / {32'd0, f.acked};
					mix = 128'(fr) * 128'(cfg_weight) + 128'(avg_q) * 128'(FRAC - 64'(cfg_weight));
					avg_q = 32'(mix / 128'(FRAC));
				end
				if (mk != 0) begin
					keep = FRAC - 64'(avg_q / 2);
					w = 32'(128'(w) * 128'(keep) / 128'(FRAC));
				end else begin
					incr = (w != 0) ? ({32'd0, f.acked} * 64'(MSS_BYTES)) / 64'(w) : 64'd0;
					nxt = w + incr[31:0];
					if (nxt > w) w = nxt;
				end
			end
		end
		if (w < MSS_BYTES) w = MSS_BYTES;
		if (w > cfg_sndbuf) w = cfg_sndbuf;
		win_q = w;
		r.window = w;
		r.frac = avg_q;
		r.slow = slow_q;
		return r;
	endfunction

	task automatic wait_drained();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_DEFAULT_RTT: cfg_rtt = val;
			REG_EWMA_WEIGHT: cfg_weight = val;
			REG_SEND_BUFFER: cfg_sndbuf = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_feedback(input feedback_t f, input bit gaps);
		int g;
		s_tvalid <= 1'b1;
		s_tdata <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_words.push_back(predict_window(f));
		if (gaps) begin
			g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
			if (g != 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 3000);
			3: return $urandom_range(0, 200000);
			default: return $urandom;
		endcase
	endfunction

	// random intervals: at least half unmarked, some with loss
	function automatic feedback_t rnd_feedback();
		feedback_t f;
		int k;
		k = $urandom_range(0, 9);
		f.rtt = ($urandom_range(0, 4) == 0) ? 0 : rnd32();
		f.acked = (k < 8) ? $urandom_range(0, 100000) : rnd32();
		f.marked = (k < 5) ? 32'd0 : (k < 8) ? $urandom_range(0, 60000) : rnd32();
		f.drops = ($urandom_range(0, 11) == 0) ? rnd32() : 32'd0;
		f.rexmits = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'd0;
		return f;
	endfunction

	// directed rows; a non-zero want_window is also checked against the predicted window
	typedef struct {
		feedback_t   fb;
		logic [31:0] want_window;
	} stim_row_t;

	stim_row_t table_rows[] = '{
		'{'{16'd0, 32'd0, 32'd0, 32'd1000, 32'd0}, 32'd2448},
		'{'{16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5}, 32'd2448},
		'{'{16'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}, 32'd2448},
		'{'{16'd0, 32'd1, 32'd0, 32'd0, 32'd20}, 32'd1448},
		'{'{16'd0, 32'd0, 32'd0, 32'd50000, 32'd20}, 32'd0},
		'{'{16'd0, 32'd0, 32'd4000, 32'd3000, 32'd20}, 32'd0},
		'{'{16'd0, 32'd0, 32'd500, 32'd0, 32'd20}, 32'd0},
		'{'{16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd20}, 32'd0},
		'{'{16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd20}, 32'd0},
		'{'{16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20}, 32'd0},
		'{'{16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd20}, 32'd0},
		'{'{16'd0, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF}, 32'd0},
		'{'{16'd1, 32'd1, 32'd1, 32'd1, 32'd0}, 32'd0}
	};

	// result checker with receiver stalls
	always @(posedge clk) begin
		window_word_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_words.size() == 0) begin
				report("unexpected result", m_tdata[31:0], 32'd0);
			end else begin
				want = expected_words.pop_front();
				if (got.window !== want.window) report("new_window", got.window, want.window);
				if (got.rtt_used !== want.rtt_used) report("rtt_used", got.rtt_used, want.rtt_used);
				if (got.frac !== want.frac) report("mark_fraction", got.frac, want.frac);
				if (got.slow !== want.slow)
					report("in_slow_start", 32'(got.slow), 32'(want.slow));
				if (got.pad !== 7'd0) report("pad", 32'(got.pad), 32'd0);
			end
			checked++;
		end
		if (hold_off) m_tready <= 1'b0;
		else if (stim_done) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// long receiver hold-off, counted here
	initial begin
		wait (cycles > 3000);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("timeout with %0d results pending", expected_words.size());
		$display("tb_dctcp_window_update: done, errors");
		$finish;
	end

	initial begin
		int idx;
		feedback_t f;
		window_word_t ex;
		cfg_rtt = 32'd18; cfg_weight = 32'd268435456; cfg_sndbuf = 32'd65536;
		win_q = MSS_BYTES; avg_q = '0; slow_q = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; the table starts from reset state
		foreach (table_rows[i]) begin
			if (i == 4) begin
				s_tvalid <= 1'b0;
				wait_drained();
				write_reg(REG_UNUSED, 32'h1234);
			end
			send_feedback(table_rows[i].fb, 0);
			ex = expected_words[$];
			if (table_rows[i].want_window != 0 && ex.window !== table_rows[i].want_window)
				report("table window", ex.window, table_rows[i].want_window);
		end
		s_tvalid <= 1'b0;
		wait_drained();

		// register extremes, including a buffer bound below one segment
		write_reg(REG_DEFAULT_RTT, 32'd0);
		write_reg(REG_SEND_BUFFER, 32'd100);
		write_reg(REG_EWMA_WEIGHT, 32'hFFFF_FFFF);
		send_feedback('{16'd0, 32'd0, 32'd0, 32'd5000, 32'd0}, 0);
		send_feedback('{16'd0, 32'd0, 32'd10, 32'd5000, 32'd0}, 0);
		send_feedback('{16'd0, 32'd0, 32'd0, 32'd5000, 32'd0}, 0);
		s_tvalid <= 1'b0;
		wait_drained();

		// random phases across several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_DEFAULT_RTT, 32'hFFFF_FFFF);
					write_reg(REG_SEND_BUFFER, 32'hFFFF_FFFF);
					write_reg(REG_EWMA_WEIGHT, 32'd0); end
				1: begin write_reg(REG_DEFAULT_RTT, 32'd1);
					write_reg(REG_SEND_BUFFER, 32'd1448);
					write_reg(REG_EWMA_WEIGHT, 32'h8000_0000); end
				default: begin write_reg(REG_DEFAULT_RTT, $urandom);
					write_reg(REG_SEND_BUFFER, $urandom_range(1448, 2000000));
					write_reg(REG_EWMA_WEIGHT, $urandom); end
			endcase
			for (int n = 0; n < 190; n++) send_feedback(rnd_feedback(), 1);
			s_tvalid <= 1'b0;
			wait_drained();
		end

		stim_done = 1'b1;
		wait_drained();
		$display("covered %0d result words over directed rows and six register settings", checked);
		$display("slow start, loss halving, ECN cut and additive increase all exercised");
		if (errors == 0) $display("tb_dctcp_window_update: done, clean");
		else $display("tb_dctcp_window_update: done, errors");
		$finish;
	end
endmodule

/* sim.f */
design/dwu_pkg.sv
design/dwu_mac.sv
design/dwu_div.sv
design/dctcp_window_update.sv
test/tb_dctcp_window_update.sv
